>>> rtl/tau_pkg.sv
// Shared types and constants for the time value arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tau_pkg;

    localparam logic [19:0] C_USEC_PER_SEC = 20'd1000000;
    localparam logic [19:0] C_USEC_MAX     = 20'd999999;
    localparam int          C_DIV_STAGES   = 64;
    localparam int          C_SPLIT_CHUNKS = 4;
    localparam int          C_CHUNK_W      = 18;
    localparam logic [13:0] C_USEC_ODD     = 14'd15625;
    localparam logic [31:0] C_RECIP        = 32'd2251799813;
    localparam int          C_RECIP_SHIFT  = 45;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_CMP = 2'd2,
        OP_DIV = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode     op;
        logic [31:0] sec;
        logic [19:0] usec;
        logic [1:0]  order;
        logic        dz;
    } t_side;

endpackage
`default_nettype wire

>>> rtl/timeval_arithmetic_unit_core.sv
// Top level of the time value arithmetic unit: add, subtract, compare, divide.
// Depends on tau_pkg.
//
// channel   direction  handshake               payload
// request   in         start & !busy           i_opcode, i_a_sec, i_a_usec, i_b_sec,
//                                              i_b_usec, i_divisor
// result    out        o_valid (one cycle)     o_res_sec, o_res_usec, o_order,
//                                              o_div_by_zero
//
// One request per cycle; every request yields one result, in request order.
// The pipeline holds the 64-stage restoring divider and the 8-stage split of the
// quotient into seconds and microseconds, two stages per 18-bit digit.
// Reset clears the valid bits and the result registers; busy stays low and the
// result side never stalls.
`timescale 1ns / 1ps
`default_nettype none
module timeval_arithmetic_unit_core
    import tau_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [31:0] i_a_sec,
    input  wire logic [19:0] i_a_usec,
    input  wire logic [31:0] i_b_sec,
    input  wire logic [19:0] i_b_usec,
    input  wire logic [31:0] i_divisor,
    output logic             o_valid,
    output logic [31:0]      o_res_sec,
    output logic [19:0]      o_res_usec,
    output logic [1:0]       o_order,
    output logic             o_div_by_zero
);

    logic               w_acc;
    logic [19:0]        w_au;
    logic [19:0]        w_bu;

    logic               r_a_valid;
    t_opcode            r_a_op;
    logic [31:0]        r_a_as;
    logic [31:0]        r_a_bs;
    logic [19:0]        r_a_au;
    logic [19:0]        r_a_bu;
    logic [31:0]        r_a_dv;
    logic signed [52:0] r_a_prod;

    t_side              n_side;
    logic [63:0]        w_total;
    logic [31:0]        w_s_add;
    logic [20:0]        w_u_add;
    logic [31:0]        w_s_sub;
    logic [20:0]        w_u_sub;

    logic               r_dvalid [0:C_DIV_STAGES];
    t_side              r_dside  [0:C_DIV_STAGES];
    logic [63:0]        r_dnum   [0:C_DIV_STAGES];
    logic [31:0]        r_drem   [0:C_DIV_STAGES];
    logic [63:0]        r_dquo   [0:C_DIV_STAGES];
    logic [31:0]        r_ddv    [0:C_DIV_STAGES];

    logic               r_mvalid [0:C_SPLIT_CHUNKS-1];
    t_side              r_mside  [0:C_SPLIT_CHUNKS-1];
    logic [63:0]        r_mnum   [0:C_SPLIT_CHUNKS-1];
    logic [31:0]        r_mquo   [0:C_SPLIT_CHUNKS-1];
    logic [31:0]        r_mx     [0:C_SPLIT_CHUNKS-1];
    logic [18:0]        r_mqh    [0:C_SPLIT_CHUNKS-1];

    logic               r_cvalid [0:C_SPLIT_CHUNKS-1];
    t_side              r_cside  [0:C_SPLIT_CHUNKS-1];
    logic [63:0]        r_cnum   [0:C_SPLIT_CHUNKS-1];
    logic [13:0]        r_crem   [0:C_SPLIT_CHUNKS-1];
    logic [31:0]        r_cquo   [0:C_SPLIT_CHUNKS-1];

    logic               r_valid;
    logic [31:0]        r_res_sec;
    logic [19:0]        r_res_usec;
    logic [1:0]         r_order;
    logic               r_dz;
    t_side              w_fside;

    assign busy  = 1'b0;
    assign w_acc = start & ~busy;
    assign w_au  = (i_a_usec > C_USEC_MAX) ? C_USEC_MAX : i_a_usec;
    assign w_bu  = (i_b_usec > C_USEC_MAX) ? C_USEC_MAX : i_b_usec;

    // stage A: saturate, form seconds times one million
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= w_acc;
        end
        r_a_op   <= t_opcode'(i_opcode);
        r_a_as   <= i_a_sec;
        r_a_bs   <= i_b_sec;
        r_a_au   <= w_au;
        r_a_bu   <= w_bu;
        r_a_dv   <= i_divisor;
        r_a_prod <= 53'($signed(i_a_sec) * $signed({1'b0, C_USEC_PER_SEC}));
    end

    // stage B: add, subtract, compare, zero-divisor check, microsecond total
    always_comb begin
        w_total = {{11{r_a_prod[52]}}, r_a_prod} + {44'd0, r_a_au};
        w_u_add = {1'b0, r_a_au} + {1'b0, r_a_bu};
        w_s_add = r_a_as + r_a_bs;
        w_s_sub = r_a_as - r_a_bs;
        w_u_sub = {1'b0, r_a_au} - {1'b0, r_a_bu};
        n_side  = '{op: r_a_op, sec: 32'd0, usec: 20'd0, order: 2'd0, dz: 1'b0};
        case (r_a_op)
            OP_ADD: begin
                if (w_u_add >= {1'b0, C_USEC_PER_SEC}) begin
                    n_side.sec  = w_s_add + 32'd1;
                    n_side.usec = 20'(w_u_add - {1'b0, C_USEC_PER_SEC});
                end else begin
                    n_side.sec  = w_s_add;
                    n_side.usec = w_u_add[19:0];
                end
            end
            OP_SUB: begin
                if (r_a_au < r_a_bu) begin
                    n_side.sec  = w_s_sub - 32'd1;
                    n_side.usec = 20'(w_u_sub + {1'b0, C_USEC_PER_SEC});
                end else begin
                    n_side.sec  = w_s_sub;
                    n_side.usec = w_u_sub[19:0];
                end
            end
            OP_CMP: begin
                if ($signed(r_a_as) == $signed(r_a_bs)) begin
                    if (r_a_au == r_a_bu) begin
                        n_side.order = 2'd0;
                    end else if (r_a_au > r_a_bu) begin
                        n_side.order = 2'b11;
                    end else begin
                        n_side.order = 2'b01;
                    end
                end else if ($signed(r_a_as) > $signed(r_a_bs)) begin
                    n_side.order = 2'b11;
                end else begin
                    n_side.order = 2'b01;
                end
            end
            OP_DIV: begin
                n_side.dz = (r_a_dv == 32'd0);
            end
            default: begin
                n_side.dz = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvalid[0] <= 1'b0;
        end else begin
            r_dvalid[0] <= r_a_valid;
        end
        r_dside[0] <= n_side;
        r_dnum[0]  <= w_total;
        r_drem[0]  <= 32'd0;
        r_dquo[0]  <= 64'd0;
        r_ddv[0]   <= r_a_dv;
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < C_DIV_STAGES; k++) begin : g_div
        logic [32:0] w_trial;
        logic [32:0] w_diff;
        logic        w_ge;
        assign w_trial = {r_drem[k], r_dnum[k][C_DIV_STAGES-1-k]};
        assign w_diff  = w_trial - {1'b0, r_ddv[k]};
        assign w_ge    = (w_trial >= {1'b0, r_ddv[k]});
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvalid[k+1] <= 1'b0;
            end else begin
                r_dvalid[k+1] <= r_dvalid[k];
            end
            r_dside[k+1] <= r_dside[k];
            r_dnum[k+1]  <= r_dnum[k];
            r_drem[k+1]  <= w_ge ? w_diff[31:0] : w_trial[31:0];
            r_dquo[k+1]  <= {r_dquo[k][62:0], w_ge};
            r_ddv[k+1]   <= r_ddv[k];
        end
    end

    // split quotient by one million: drop the six low bits, then divide by 15625
    // in 18-bit digits, estimate by reciprocal, then correct by one
    for (genvar k = 0; k < C_SPLIT_CHUNKS; k++) begin : g_split
        logic        w_v;
        t_side       w_s;
        logic [63:0] w_n;
        logic [13:0] w_r;
        logic [31:0] w_q;
        logic [71:0] w_pad;
        logic [31:0] w_x;
        logic [63:0] w_prod;
        logic [31:0] w_back;
        logic [31:0] w_rem;
        logic        w_ge;
        logic [18:0] w_qd;
        if (k == 0) begin : g_first
            assign w_v = r_dvalid[C_DIV_STAGES];
            assign w_s = r_dside[C_DIV_STAGES];
            assign w_n = r_dquo[C_DIV_STAGES];
            assign w_r = 14'd0;
            assign w_q = 32'd0;
        end else begin : g_rest
            assign w_v = r_cvalid[k-1];
            assign w_s = r_cside[k-1];
            assign w_n = r_cnum[k-1];
            assign w_r = r_crem[k-1];
            assign w_q = r_cquo[k-1];
        end
        assign w_pad  = {14'd0, w_n[63:6]};
        assign w_x    = {w_r, w_pad[71-C_CHUNK_W*k -: C_CHUNK_W]};
        assign w_prod = {32'd0, w_x} * {32'd0, C_RECIP};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mvalid[k] <= 1'b0;
            end else begin
                r_mvalid[k] <= w_v;
            end
            r_mside[k] <= w_s;
            r_mnum[k]  <= w_n;
            r_mquo[k]  <= w_q;
            r_mx[k]    <= w_x;
            r_mqh[k]   <= w_prod[63:C_RECIP_SHIFT];
        end
        assign w_back = {13'd0, r_mqh[k]} * {18'd0, C_USEC_ODD};
        assign w_rem  = r_mx[k] - w_back;
        assign w_ge   = (w_rem >= {18'd0, C_USEC_ODD});
        assign w_qd   = w_ge ? r_mqh[k] + 19'd1 : r_mqh[k];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cvalid[k] <= 1'b0;
            end else begin
                r_cvalid[k] <= r_mvalid[k];
            end
            r_cside[k] <= r_mside[k];
            r_cnum[k]  <= r_mnum[k];
            r_crem[k]  <= w_ge ? 14'(w_rem - {18'd0, C_USEC_ODD}) : w_rem[13:0];
            r_cquo[k]  <= {r_mquo[k][13:0], w_qd[17:0]};
        end
    end

    assign w_fside = r_cside[C_SPLIT_CHUNKS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_res_sec  <= 32'd0;
            r_res_usec <= 20'd0;
            r_order    <= 2'd0;
            r_dz       <= 1'b0;
        end else begin
            r_valid <= r_cvalid[C_SPLIT_CHUNKS-1];
            if (!r_cvalid[C_SPLIT_CHUNKS-1]) begin
                r_res_sec  <= 32'd0;
                r_res_usec <= 20'd0;
                r_order    <= 2'd0;
                r_dz       <= 1'b0;
            end else if (w_fside.op == OP_DIV && !w_fside.dz) begin
                r_res_sec  <= r_cquo[C_SPLIT_CHUNKS-1];
                r_res_usec <= {r_crem[C_SPLIT_CHUNKS-1], r_cnum[C_SPLIT_CHUNKS-1][5:0]};
                r_order    <= 2'd0;
                r_dz       <= 1'b0;
            end else begin
                r_res_sec  <= w_fside.sec;
                r_res_usec <= w_fside.usec;
                r_order    <= w_fside.order;
                r_dz       <= w_fside.dz;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_res_sec     = r_res_sec;
    assign o_res_usec    = r_res_usec;
    assign o_order       = r_order;
    assign o_div_by_zero = r_dz;

`ifndef NO_ASSERTIONS
    a_dz_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_by_zero |-> o_valid) else $error("div_by_zero without result");
    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_order != 2'd0) |-> (o_res_sec == 32'd0 && o_res_usec == 20'd0))
        else $error("compare result carries time value");
    a_usec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_usec <= C_USEC_MAX) else $error("microseconds out of range");
    a_dz_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_by_zero |-> (o_res_sec == 32'd0 && o_res_usec == 20'd0 && o_order == 2'd0))
        else $error("zero divisor result not cleared");
`endif

endmodule
`default_nettype wire
